FILE: design/mau_pkg.sv
// Shared types, opcodes and helpers for the modular arithmetic unit.
// No dependencies.
package mau_pkg;

	localparam int RES_W = 31;
	localparam int OPD_W = 64;
	localparam int CNT_W = 5;
	localparam int SGN_W = RES_W + 3;

	localparam logic [RES_W-1:0] MOD_RESET = 31'd1000000007;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_POW = 3'd4;
	localparam logic [2:0] OP_NEG = 3'd5;
	localparam logic [2:0] OP_INV = 3'd6;
	localparam logic [2:0] OP_EQU = 3'd7;

	typedef logic [RES_W-1:0] res_t;

	typedef struct packed {
		logic start;
	} mul_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

	// Sum of two residues, folded back below m.
	function automatic res_t addmod(input res_t x, input res_t y, input res_t m);
		logic [RES_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[RES_W-1:0];
	endfunction

endpackage

FILE: design/mau_mulmod.sv
// Bit-serial modular multiplier: two products x1*y and x2*y mod m, one bit of y a cycle.
// Depends on mau_pkg.
module mau_mulmod (
	input  logic              clk,
	input  logic              arst_n,
	input  mau_pkg::res_t     m,
	input  mau_pkg::res_t     x1,
	input  mau_pkg::res_t     x2,
	input  mau_pkg::res_t     y,
	input  mau_pkg::mul_req_t req,
	output mau_pkg::mul_stat_t stat,
	output mau_pkg::res_t     p1,
	output mau_pkg::res_t     p2
);
	import mau_pkg::*;

	res_t             acc1_q, acc2_q, x1_q, x2_q, y_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	res_t             dbl1, dbl2;

	// Double both accumulators modulo m.
	always_comb begin
		dbl1 = addmod(acc1_q, acc1_q, m);
		dbl2 = addmod(acc2_q, acc2_q, m);
	end

	// Control: count through the multiplier bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(RES_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift-add, most significant multiplier bit first.
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc1_q <= '0;
			acc2_q <= '0;
			x1_q   <= x1;
			x2_q   <= x2;
			y_q    <= y;
		end else if (busy_q) begin
			acc1_q <= y_q[RES_W-1] ? addmod(dbl1, x1_q, m) : dbl1;
			acc2_q <= y_q[RES_W-1] ? addmod(dbl2, x2_q, m) : dbl2;
			y_q    <= {y_q[RES_W-2:0], 1'b0};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign p1 = acc1_q;
	assign p2 = acc2_q;

endmodule

FILE: design/modular_arithmetic_unit.sv
// Modular arithmetic unit: top level with handshakes, modulus register and sequencer.
// Depends on mau_pkg and mau_mulmod.
//
// One word is in work at a time. Operand reduction shifts in one bit of each operand a
// cycle. Add, sub, neg and equal need no multiplier pass; mul adds one pass of the
// bit-serial multiplier. Inverse runs extended Euclid with a bit-serial division per
// quotient, up to about 45 quotients; divide adds one multiply to that. Power takes
// one multiplier pass per exponent bit up to its highest set bit. A finished result
// waits in the output register; a modulus of 0 or 1 acts as modulus 1.
module modular_arithmetic_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [2:0]                opcode,
	input  logic signed [63:0]        operand_a,
	input  logic signed [63:0]        operand_b,
	input  logic [63:0]               exponent,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [mau_pkg::RES_W-1:0] result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [mau_pkg::RES_W-1:0] cfg_data
);
	import mau_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RED   = 4'd1;
	localparam logic [3:0] ST_SIGN  = 4'd2;
	localparam logic [3:0] ST_DISP  = 4'd3;
	localparam logic [3:0] ST_ECHK  = 4'd4;
	localparam logic [3:0] ST_EDIV  = 4'd5;
	localparam logic [3:0] ST_EUPD  = 4'd6;
	localparam logic [3:0] ST_EFIX  = 4'd7;
	localparam logic [3:0] ST_MGO   = 4'd8;
	localparam logic [3:0] ST_MWAIT = 4'd9;
	localparam logic [3:0] ST_PCHK  = 4'd10;
	localparam logic [3:0] ST_PWAIT = 4'd11;
	localparam logic [3:0] ST_DONE  = 4'd12;

	logic [3:0]              state_q;
	res_t                    mod_q, m;
	logic [2:0]              op_q;
	logic [OPD_W-1:0]        ma_q, mb_q, k_q;
	logic                    nega_q, negb_q;
	logic [5:0]              rcnt_q;
	res_t                    rema_q, remb_q, a_q, b_q;
	res_t                    ea_q, eb_q, erem_q, edq_q;
	logic signed [SGN_W-1:0] eu_q, ev_q, prod_q;
	logic [CNT_W-1:0]        ecnt_q;
	res_t                    pr_q, pb_q, mx1_q, my_q, res_q;
	logic                    out_valid_q;
	res_t                    result_q;

	logic [RES_W:0]          ta, tb, te;
	logic                    ge_e;
	logic [SGN_W-1:0]        umag, ufix;
	res_t                    inv_val, neg_b;
	mul_req_t                mreq;
	mul_stat_t               mstat;
	res_t                    p1, p2;

	assign m = (mod_q < RES_W'(2)) ? RES_W'(1) : mod_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign result    = result_q;

	// Reduction and division steps: shift one bit in, subtract when it fits.
	always_comb begin
		ta   = {rema_q, ma_q[OPD_W-1]};
		tb   = {remb_q, mb_q[OPD_W-1]};
		te   = {erem_q, edq_q[RES_W-1]};
		ge_e = (te >= {1'b0, eb_q});
		if (ta >= {1'b0, m}) ta = ta - {1'b0, m};
		if (tb >= {1'b0, m}) tb = tb - {1'b0, m};
		if (ge_e) te = te - {1'b0, eb_q};
	end

	// Fold the Euclid coefficient into range.
	always_comb begin
		umag = '0;
		ufix = '0;
		inv_val = '0;
		if (eu_q[SGN_W-1]) begin
			umag = -eu_q;
			if (umag >= {3'b0, m}) umag = umag - {3'b0, m};
			inv_val = (umag == '0) ? '0 : m - umag[RES_W-1:0];
		end else begin
			ufix = eu_q;
			if (ufix >= {3'b0, m}) ufix = ufix - {3'b0, m};
			inv_val = ufix[RES_W-1:0];
		end
	end

	assign neg_b = (b_q == '0) ? '0 : m - b_q;

	assign mreq.start = (state_q == ST_MGO) ||
		(state_q == ST_PCHK && k_q != '0);

	mau_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.m      (m),
		.x1     ((state_q == ST_PCHK) ? pr_q : mx1_q),
		.x2     (pb_q),
		.y      ((state_q == ST_PCHK) ? pb_q : my_q),
		.req    (mreq),
		.stat   (mstat),
		.p1     (p1),
		.p2     (p2)
	);

	// Hold the modulus register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			mod_q <= cfg_data;
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// Raise the output word when a result lands, drop it once taken.
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_RED;
				end
				ST_RED: begin
					if (rcnt_q == 6'd63) state_q <= ST_SIGN;
				end
				ST_SIGN: state_q <= ST_DISP;
				ST_DISP: begin
					priority case (op_q)
						OP_MUL: state_q <= ST_MGO;
						OP_POW: state_q <= ST_PCHK;
						OP_DIV, OP_INV: state_q <= ST_ECHK;
						default: state_q <= ST_DONE;
					endcase
				end
				ST_ECHK: state_q <= (eb_q == '0) ? ST_EFIX : ST_EDIV;
				ST_EDIV: begin
					if (ecnt_q == CNT_W'(RES_W - 1)) state_q <= ST_EUPD;
				end
				ST_EUPD: state_q <= ST_ECHK;
				ST_EFIX: state_q <= (op_q == OP_DIV) ? ST_MGO : ST_DONE;
				ST_MGO: state_q <= ST_MWAIT;
				ST_MWAIT: begin
					if (mstat.done) state_q <= ST_DONE;
				end
				ST_PCHK: state_q <= (k_q == '0) ? ST_DONE : ST_PWAIT;
				ST_PWAIT: begin
					if (mstat.done) state_q <= ST_PCHK;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_q   <= opcode;
				nega_q <= operand_a[OPD_W-1];
				negb_q <= operand_b[OPD_W-1];
				ma_q   <= operand_a[OPD_W-1] ? -operand_a : operand_a;
				mb_q   <= operand_b[OPD_W-1] ? -operand_b : operand_b;
				k_q    <= exponent;
				rema_q <= '0;
				remb_q <= '0;
				rcnt_q <= '0;
			end
			ST_RED: begin
				rema_q <= ta[RES_W-1:0];
				remb_q <= tb[RES_W-1:0];
				ma_q   <= {ma_q[OPD_W-2:0], 1'b0};
				mb_q   <= {mb_q[OPD_W-2:0], 1'b0};
				rcnt_q <= rcnt_q + 1'b1;
			end
			ST_SIGN: begin
				a_q <= (nega_q && rema_q != '0) ? m - rema_q : rema_q;
				b_q <= (negb_q && remb_q != '0) ? m - remb_q : remb_q;
			end
			ST_DISP: begin
				// Start Euclid on the divisor residue for divide, on the operand a residue for inverse.
				ea_q  <= (op_q == OP_DIV) ? b_q : a_q;
				eb_q  <= m;
				eu_q  <= SGN_W'(1);
				ev_q  <= '0;
				mx1_q <= a_q;
				my_q  <= b_q;
				pr_q  <= (m == RES_W'(1)) ? '0 : RES_W'(1);
				pb_q  <= a_q;
				unique case (op_q)
					OP_ADD: res_q <= addmod(a_q, b_q, m);
					OP_SUB: res_q <= addmod(a_q, neg_b, m);
					OP_NEG: res_q <= (a_q == '0) ? '0 : m - a_q;
					OP_EQU: res_q <= {{(RES_W-1){1'b0}}, a_q == b_q};
					default: res_q <= '0;
				endcase
			end
			ST_ECHK: begin
				erem_q <= '0;
				edq_q  <= ea_q;
				prod_q <= '0;
				ecnt_q <= '0;
			end
			ST_EDIV: begin
				erem_q <= te[RES_W-1:0];
				edq_q  <= {edq_q[RES_W-2:0], 1'b0};
				prod_q <= (prod_q <<< 1) + (ge_e ? ev_q : '0);
				ecnt_q <= ecnt_q + 1'b1;
			end
			ST_EUPD: begin
				ea_q <= eb_q;
				eb_q <= erem_q;
				eu_q <= ev_q;
				ev_q <= eu_q - prod_q;
			end
			ST_EFIX: begin
				res_q <= inv_val;
				my_q  <= inv_val;
			end
			ST_MWAIT: begin
				if (mstat.done) res_q <= p1;
			end
			ST_PCHK: begin
				if (k_q == '0) res_q <= pr_q;
			end
			ST_PWAIT: begin
				if (mstat.done) begin
					if (k_q[0]) pr_q <= p1;
					pb_q <= p2;
					k_q  <= {1'b0, k_q[OPD_W-1:1]};
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) result_q <= res_q;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: tb/modular_arithmetic_unit_tb.sv
// Testbench for the modular arithmetic unit: predicts each residue result in the bench
// and checks every output word in order. Depends on mau_pkg and the unit's RTL.
`timescale 1ns / 1ps

module modular_arithmetic_unit_tb;
	import mau_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [2:0]        opcode;
	logic signed [63:0] operand_a;
	logic signed [63:0] operand_b;
	logic [63:0]       exponent;
	logic              out_valid;
	logic              out_ready;
	logic [RES_W-1:0]  result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [RES_W-1:0]  cfg_data;

	logic [63:0]       cur_modulus;
	logic [RES_W-1:0]  pending_residues[$];
	int                mismatch_count;
	int                send_idle_pct;
	int                recv_idle_pct;
	int                hold_off_cycles;

	modular_arithmetic_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .operand_a(operand_a), .operand_b(operand_b),
		.exponent(exponent),
		.out_valid(out_valid), .out_ready(out_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Reduce a signed 64-bit operand into 0..m-1.
	function automatic logic [63:0] residue_of(input logic [63:0] raw, input logic [63:0] m);
		logic [63:0] rem;
		if (!raw[63]) begin
			return raw % m;
		end
		rem = ((~raw) + 64'd1) % m;
		return (rem == 0) ? 64'd0 : m - rem;
	endfunction

	// Extended Euclid coefficient, reduced into range.
	function automatic logic [63:0] euclid_inverse(input logic [63:0] x, input logic [63:0] m);
		longint a, b, u, v, q, tmp;
		a = x; b = m; u = 1; v = 0;
		while (b != 0) begin
			q = a / b;
			a = a - q * b;
			tmp = a; a = b; b = tmp;
			u = u - q * v;
			tmp = u; u = v; v = tmp;
		end
		if (u < 0) begin
			return residue_of(u, m);
		end
		return u % m;
	endfunction

	function automatic logic [63:0] power_mod(input logic [63:0] base, input logic [63:0] k,
			input logic [63:0] m);
		logic [63:0] acc;
		acc = 64'd1 % m;
		while (k != 0) begin
			if (k[0]) begin
				acc = (acc * base) % m;
			end
			base = (base * base) % m;
			k = k >> 1;
		end
		return acc;
	endfunction

	function automatic logic [RES_W-1:0] predict_residue(input logic [2:0] op,
			input logic [63:0] ra, input logic [63:0] rb, input logic [63:0] k);
		logic [63:0] m, a, b, r;
		m = (cur_modulus < 2) ? 64'd1 : cur_modulus;
		a = residue_of(ra, m);
		b = residue_of(rb, m);
		case (op)
			OP_ADD: r = (a + b) % m;
			OP_SUB: r = (a + m - b) % m;
			OP_MUL: r = (a * b) % m;
			OP_DIV: r = (a * euclid_inverse(b, m)) % m;
			OP_POW: r = power_mod(a, k, m);
			OP_NEG: r = (a == 0) ? 64'd0 : m - a;
			OP_INV: r = euclid_inverse(a, m);
			default: r = (a == b) ? 64'd1 : 64'd0;
		endcase
		return r[RES_W-1:0];
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Send one word, idling at random first; valid stays up for a back-to-back word.
	task automatic send_word(input logic [2:0] op, input logic [63:0] ra,
			input logic [63:0] rb, input logic [63:0] k);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		operand_a <= ra;
		operand_b <= rb;
		exponent <= k;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		pending_residues.push_back(predict_residue(op, ra, rb, k));
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_residues.size() != 0) begin
			@(negedge clk);
		end
		repeat (20) @(negedge clk);
	endtask

	task automatic write_modulus(input logic [RES_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cur_modulus = 64'(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] rand_operand();
		case ($urandom_range(5))
			0: return 64'h8000_0000_0000_0000;
			1: return 64'h7FFF_FFFF_FFFF_FFFF;
			2: return 64'($urandom_range(20)) - 64'd10;
			3: return -(cur_modulus * $urandom_range(4));
			default: return rand64();
		endcase
	endfunction

	task automatic test_directed();
		logic [63:0] m;
		m = cur_modulus;
		for (int op = 0; op < 8; op++) begin
			send_word(3'(op), 64'd5, 64'd3, 64'd7);
		end
		send_word(OP_ADD, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
		send_word(OP_SUB, -64'sd1, -m, 64'd0);
		send_word(OP_MUL, -(m * 3), m - 1, 64'd0);
		send_word(OP_DIV, 64'd9, 64'd0, 64'd0);
		send_word(OP_DIV, 64'd9, m, 64'd0);
		send_word(OP_INV, 64'd0, 64'd1, 64'd0);
		send_word(OP_INV, m - 1, 64'd0, 64'd0);
		send_word(OP_POW, 64'd2, 64'd0, 64'd0);
		send_word(OP_POW, m - 1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(OP_POW, 64'd3, 64'd0, 64'h8000_0000_0000_0000);
		send_word(OP_NEG, 64'd0, 64'd0, 64'd0);
		send_word(OP_EQU, -64'sd1, m - 1, 64'd0);
		send_word(OP_EQU, 64'd1, 64'd2, 64'd0);
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++) begin
			send_word(3'($urandom_range(7)), rand_operand(), rand_operand(), rand64());
		end
	endtask

	// Stall the receiver long enough that the unit backs up its input.
	task automatic test_backpressure();
		hold_off_cycles = 6000;
		test_random(4);
		drain_results();
	endtask

	task automatic test_modulus_sweep();
		write_modulus(31'd2);
		test_random(30);
		write_modulus(31'h7FFF_FFFF);
		test_random(40);
		write_modulus(31'd12);
		test_random(30);
		write_modulus(31'd0);
		test_random(15);
		write_modulus(31'd1);
		test_random(15);
		write_modulus(31'd65521);
		test_random(40);
		write_modulus(MOD_RESET);
	endtask

	// Take result words and compare with the oldest prediction.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				out_ready <= 1'b0;
				hold_off_cycles--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_residues.size() == 0) begin
					report_mismatch($sformatf("unexpected result %0d", result));
				end else if (result !== pending_residues[0]) begin
					report_mismatch($sformatf("result %0d, predicted %0d",
						result, pending_residues[0]));
					void'(pending_residues.pop_front());
				end else begin
					void'(pending_residues.pop_front());
				end
			end
		end
	end

	initial begin
		#100_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_ADD;
		operand_a = '0;
		operand_b = '0;
		exponent = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		cur_modulus = 64'(MOD_RESET);
		mismatch_count = 0;
		send_idle_pct = 20;
		recv_idle_pct = 20;
		hold_off_cycles = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_backpressure();
		write_modulus(31'd97);
		test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(60);
		send_idle_pct = 20;
		recv_idle_pct = 20;
		test_modulus_sweep();
		test_random(120);

		drain_results();
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
